### hdl/lot_pkg.sv
// Package for the lock ownership table: field widths, default sizes, codes and types.
// Used by lot_mod_unit and lock_ownership_table; depends on nothing else.
package lot_pkg;

    localparam int ADDR_W           = 32;
    localparam int ID_W             = 32;
    localparam int FILE_W           = 16;
    localparam int LINE_W           = 16;
    localparam int SLOT_IDX_W       = 5;
    localparam int DIGIT_W          = 8;
    localparam int ID_STEPS         = ID_W / DIGIT_W;
    localparam int DEF_TABLE_SLOTS  = 32;
    localparam int DEF_HASH_BUCKETS = 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HELD     = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_HELD = 2'd3
    } status_t;

    typedef enum logic {
        REQ_GRAB    = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               step;
        logic [DIGIT_W-1:0] digit;
    } mod_ctrl_t;

endpackage

### hdl/lot_mod_unit.sv
// Byte-serial remainder unit: reduces a number fed most significant byte first modulo
// HASH_BUCKETS with two constant residue tables and one compare and subtract per step.
// Depends on lot_pkg for the control struct, the digit width and the default bucket count.
module lot_mod_unit #(
    parameter int HASH_BUCKETS = lot_pkg::DEF_HASH_BUCKETS,
    localparam int BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lot_pkg::mod_ctrl_t  ctrl,
    output logic [BW-1:0]       rem
);

    localparam int DW    = lot_pkg::DIGIT_W;
    localparam int REM_N = 2 ** BW;
    localparam int DIG_N = 2 ** DW;
    localparam logic [BW:0] BUCKETS_C = (BW + 1)'(HASH_BUCKETS);

    logic [BW-1:0] scaled_tab [REM_N];
    logic [BW-1:0] digit_tab [DIG_N];
    logic [BW-1:0] rem_reg;
    logic [BW-1:0] rem_next;
    logic [BW:0]   trial;
    logic [BW:0]   trial_red;

    for (genvar g = 0; g < REM_N; g++)
    begin : g_scaled
        assign scaled_tab[g] = BW'((g * DIG_N) % HASH_BUCKETS);
    end

    for (genvar g = 0; g < DIG_N; g++)
    begin : g_digit
        assign digit_tab[g] = BW'(g % HASH_BUCKETS);
    end

    always_comb
    begin
        trial = {1'b0, scaled_tab[rem_reg]} + {1'b0, digit_tab[ctrl.digit]};
        if (trial >= BUCKETS_C)
        begin
            trial_red = trial - BUCKETS_C;
        end
        else
        begin
            trial_red = trial;
        end
        rem_next = rem_reg;
        if (ctrl.clear)
        begin
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            rem_next = trial_red[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    assign rem = rem_reg;

endmodule

### hdl/lock_ownership_table.sv
// Top level of the lock ownership table: scan sequencer, entry and free-slot memories.
// Depends on lot_pkg and instantiates lot_mod_unit for the holder bucket.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | req_type, lock_address, holder_id, source_file, source_line
//  out     | out_valid | out_stall | status, slot_index
//
// Each item is scanned with one entry memory read per slot, overlapped with one byte per
// cycle of the bucket remainder of the holder id shifted right by one bit.
// After reset every slot of the entry memory is cleared before the first item is taken.
// A finished result waits in the output register; the next item is taken meanwhile and only
// its final step holds while the output is stalled.
module lock_ownership_table #(
    parameter int TABLE_SLOTS  = lot_pkg::DEF_TABLE_SLOTS,
    parameter int HASH_BUCKETS = lot_pkg::DEF_HASH_BUCKETS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [lot_pkg::ADDR_W-1:0]    lock_address,
    input  logic [lot_pkg::ID_W-1:0]      holder_id,
    input  logic [lot_pkg::FILE_W-1:0]    source_file,
    input  logic [lot_pkg::LINE_W-1:0]    source_line,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [lot_pkg::SLOT_IDX_W-1:0] slot_index
);

    localparam int SW   = $clog2(TABLE_SLOTS);
    localparam int BW   = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam int LAST = (TABLE_SLOTS - 1 > lot_pkg::ID_STEPS) ? TABLE_SLOTS - 1
                                                                : lot_pkg::ID_STEPS;
    localparam int CW   = $clog2(LAST + 2);

    typedef struct packed {
        logic                       valid;
        logic [lot_pkg::ADDR_W-1:0] address;
        logic [BW-1:0]              bucket;
        logic [lot_pkg::FILE_W-1:0] file;
        logic [lot_pkg::LINE_W-1:0] line;
    } entry_t;

    lot_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    cyc_reg, cyc_next;
    logic [SW:0]      clr_reg, clr_next;
    logic             hit_reg, hit_next;
    logic [SW-1:0]    hit_slot_reg, hit_slot_next;
    logic [BW-1:0]    hit_bucket_reg, hit_bucket_next;
    logic [SW-1:0]    pushed_reg, pushed_next;
    logic [SW:0]      fresh_reg, fresh_next;
    logic             out_valid_reg, out_valid_next;
    lot_pkg::status_t out_status_reg, out_status_next;
    logic [lot_pkg::SLOT_IDX_W-1:0] out_slot_reg, out_slot_next;

    logic                       req_type_reg;
    logic [lot_pkg::ADDR_W-1:0] req_addr_reg;
    logic [lot_pkg::FILE_W-1:0] req_file_reg;
    logic [lot_pkg::LINE_W-1:0] req_line_reg;
    logic [lot_pkg::ID_W-1:0]   id_shift_reg;

    entry_t        entry_mem [TABLE_SLOTS];
    entry_t        entry_rd_reg;
    logic [SW-1:0] stack_mem [TABLE_SLOTS];
    logic [SW-1:0] stack_rd_reg;

    logic          ent_we;
    logic [SW-1:0] ent_waddr;
    entry_t        ent_wdata;
    logic [SW-1:0] ent_raddr;
    logic          stk_we;
    logic [SW-1:0] stk_waddr;
    logic [SW-1:0] stk_wdata;
    logic [SW-1:0] stk_raddr;

    lot_pkg::mod_ctrl_t mod_ctrl;
    logic [BW-1:0]      req_bucket;

    logic                        in_accept;
    logic [CW-1:0]               cyc_plus;
    logic                        table_full;
    logic [SW-1:0]               new_slot;
    logic [SW-1:0]               commit_slot;
    logic [SW+lot_pkg::SLOT_IDX_W-1:0] commit_slot_ext;

    lot_mod_unit #(
        .HASH_BUCKETS(HASH_BUCKETS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mod_ctrl),
        .rem   (req_bucket)
    );

    assign in_stall   = (state_reg != lot_pkg::S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_slot_reg;

    assign cyc_plus   = cyc_reg + CW'(1);
    assign stk_raddr  = (pushed_reg != '0) ? pushed_reg - SW'(1) : '0;
    assign table_full = (pushed_reg == '0) && (fresh_reg == (SW + 1)'(TABLE_SLOTS));
    assign new_slot   = (pushed_reg != '0) ? stack_rd_reg : fresh_reg[SW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cyc_next        = cyc_reg;
        clr_next        = clr_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_bucket_next = hit_bucket_reg;
        pushed_next     = pushed_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        ent_we          = 1'b0;
        ent_waddr       = '0;
        ent_wdata       = '0;
        ent_raddr       = '0;
        stk_we          = 1'b0;
        stk_waddr       = pushed_reg;
        stk_wdata       = hit_slot_reg;
        mod_ctrl        = '0;
        mod_ctrl.digit  = id_shift_reg[lot_pkg::ID_W-1 -: lot_pkg::DIGIT_W];
        commit_slot     = '0;
        commit_slot_ext = '0;

        case (state_reg)
            lot_pkg::S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg[SW-1:0];
                if (clr_reg == (SW + 1)'(TABLE_SLOTS - 1))
                begin
                    state_next = lot_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + (SW + 1)'(1);
                end
            end

            lot_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next     = lot_pkg::S_SCAN;
                    cyc_next       = '0;
                    hit_next       = 1'b0;
                    mod_ctrl.clear = 1'b1;
                end
            end

            lot_pkg::S_SCAN:
            begin
                mod_ctrl.step = (cyc_reg < CW'(lot_pkg::ID_STEPS));
                if (cyc_plus < CW'(TABLE_SLOTS))
                begin
                    ent_raddr = cyc_plus[SW-1:0];
                end
                if (cyc_reg >= CW'(1) && cyc_reg < CW'(TABLE_SLOTS) && !hit_reg
                    && entry_rd_reg.valid && entry_rd_reg.address == req_addr_reg)
                begin
                    hit_next        = 1'b1;
                    hit_slot_next   = cyc_reg[SW-1:0];
                    hit_bucket_next = entry_rd_reg.bucket;
                end
                if (cyc_reg == CW'(LAST))
                begin
                    state_next = lot_pkg::S_DECIDE;
                end
                else
                begin
                    cyc_next = cyc_plus;
                end
            end

            lot_pkg::S_DECIDE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next     = lot_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    if (req_type_reg == lot_pkg::REQ_GRAB)
                    begin
                        if (hit_reg)
                        begin
                            out_status_next = lot_pkg::ST_HELD;
                            commit_slot     = hit_slot_reg;
                        end
                        else if (table_full)
                        begin
                            out_status_next = lot_pkg::ST_FULL;
                        end
                        else
                        begin
                            out_status_next   = lot_pkg::ST_OK;
                            commit_slot       = new_slot;
                            ent_we            = 1'b1;
                            ent_waddr         = new_slot;
                            ent_wdata.valid   = 1'b1;
                            ent_wdata.address = req_addr_reg;
                            ent_wdata.bucket  = req_bucket;
                            ent_wdata.file    = req_file_reg;
                            ent_wdata.line    = req_line_reg;
                            if (pushed_reg != '0)
                            begin
                                pushed_next = pushed_reg - SW'(1);
                            end
                            else
                            begin
                                fresh_next = fresh_reg + (SW + 1)'(1);
                            end
                        end
                    end
                    else
                    begin
                        if (hit_reg && hit_bucket_reg == req_bucket)
                        begin
                            out_status_next = lot_pkg::ST_OK;
                            commit_slot     = hit_slot_reg;
                            ent_we          = 1'b1;
                            ent_waddr       = hit_slot_reg;
                            stk_we          = 1'b1;
                            pushed_next     = pushed_reg + SW'(1);
                        end
                        else
                        begin
                            out_status_next = lot_pkg::ST_NOT_HELD;
                        end
                    end
                    commit_slot_ext = (SW + lot_pkg::SLOT_IDX_W)'(commit_slot);
                    out_slot_next   = commit_slot_ext[lot_pkg::SLOT_IDX_W-1:0];
                end
            end

            default:
            begin
                state_next = lot_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lot_pkg::S_CLEAR;
            cyc_reg        <= '0;
            clr_reg        <= '0;
            hit_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            hit_bucket_reg <= '0;
            pushed_reg     <= '0;
            fresh_reg      <= (SW + 1)'(1);
            out_valid_reg  <= 1'b0;
            out_status_reg <= lot_pkg::ST_OK;
            out_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cyc_reg        <= cyc_next;
            clr_reg        <= clr_next;
            hit_reg        <= hit_next;
            hit_slot_reg   <= hit_slot_next;
            hit_bucket_reg <= hit_bucket_next;
            pushed_reg     <= pushed_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_type_reg <= req_type;
            req_addr_reg <= lock_address;
            req_file_reg <= source_file;
            req_line_reg <= source_line;
            id_shift_reg <= holder_id >> 1;
        end
        else
        begin
            id_shift_reg <= {id_shift_reg[lot_pkg::ID_W-lot_pkg::DIGIT_W-1:0],
                             {lot_pkg::DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        entry_rd_reg <= entry_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stack_rd_reg <= stack_mem[stk_raddr];
    end

    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == lot_pkg::S_DECIDE))
        else $error("result appeared without a decide step");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == lot_pkg::S_SCAN && cyc_reg == '0))
        else $error("accepted item did not start a scan");

    a_free_accounting: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg != '0) && (fresh_reg <= (SW + 1)'(TABLE_SLOTS))
        && ((SW + 1)'(pushed_reg) < fresh_reg))
        else $error("free slot accounting out of range");

    a_hold_result_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lot_pkg::S_DECIDE && out_valid_reg && out_stall)
        |=> (state_reg == lot_pkg::S_DECIDE))
        else $error("decide step committed over a pending result");

endmodule
